/* sv/crc8cfr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// crc8cfr_pkg
// Shared types, register codes and the CRC8 byte update for the frame receiver.
// ----------------------------------------------------------------------------
package crc8cfr_pkg;

	localparam int unsigned BYTE_W            = 8;
	localparam int unsigned CFG_IDX_W         = 8;
	localparam int unsigned TEXT_W            = 64;
	localparam int unsigned TEXT_LEN_W        = 4;
	localparam int unsigned LEN_W             = 6;
	localparam int unsigned MAX_FRAME_PAYLOAD = 32;
	localparam int unsigned TEXT_CHARS_DEF    = 8;
	localparam int unsigned TEXT_CHARS_MAX    = 8;
	localparam int unsigned QUEUE_DEPTH       = 2;

	localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;
	localparam logic [BYTE_W-1:0] CRC_INIT = 8'h00;

	localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'hAA;
	localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'h55;
	localparam logic [BYTE_W-1:0] INIT_TYPE_RST    = 8'h01;
	localparam logic [BYTE_W-1:0] STATE_TYPE_RST   = 8'h02;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_MARKER = 8'd0,
		REG_END_MARKER   = 8'd1,
		REG_INIT_TYPE    = 8'd2,
		REG_STATE_TYPE   = 8'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_TYPE    = 3'd1,
		PH_LEN     = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_CRC     = 3'd4,
		PH_END     = 3'd5
	} phase_t;

	typedef enum logic {
		KIND_INIT  = 1'b0,
		KIND_STATE = 1'b1
	} frame_kind_t;

	typedef struct packed {
		frame_kind_t             kind;
		logic [TEXT_W-1:0]       text;
		logic [TEXT_LEN_W-1:0]   count;
	} frame_rec_t;

	function automatic logic [BYTE_W-1:0] crc8_feed(input logic [BYTE_W-1:0] crc,
			input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] c;
		c = crc ^ b;
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[BYTE_W-1]) begin
				c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[BYTE_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

/* sv/crc8cfr_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// crc8cfr_if
// Valid/ready channels: received bytes, frame results and register writes.
// ----------------------------------------------------------------------------
interface crc8cfr_byte_if import crc8cfr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_data;
	modport source (output valid, output rx_data, input ready);
	modport sink   (input valid, input rx_data, output ready);
endinterface

interface crc8cfr_result_if import crc8cfr_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  frame_kind;
	logic [TEXT_W-1:0]     text_bytes;
	logic [TEXT_LEN_W-1:0] text_length;
	modport source (output valid, output frame_kind, output text_bytes, output text_length,
		input ready);
	modport sink   (input valid, input frame_kind, input text_bytes, input text_length,
		output ready);
endinterface

interface crc8cfr_cfg_if import crc8cfr_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [BYTE_W-1:0]    data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* sv/crc8cfr_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// crc8cfr_parser
// Front end: takes bytes, tracks frame phase, runs the CRC and emits a record
// for every accepted frame.
// ----------------------------------------------------------------------------
module crc8cfr_parser import crc8cfr_pkg::*; #(
	parameter int unsigned TEXT_CHARS = TEXT_CHARS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	crc8cfr_byte_if.sink    rx,
	crc8cfr_cfg_if.sink     cfg,
	input  wire logic       q_full,
	output logic            push,
	output frame_rec_t      rec
);

	localparam int unsigned TIDX_W = (TEXT_CHARS > 1) ? $clog2(TEXT_CHARS) : 1;

	logic [BYTE_W-1:0] start_marker_q;
	logic [BYTE_W-1:0] end_marker_q;
	logic [BYTE_W-1:0] init_type_q;
	logic [BYTE_W-1:0] state_type_q;

	phase_t            phase_q, phase_d;
	logic [BYTE_W-1:0] frame_type_q;
	logic [LEN_W-1:0]  frame_length_q;
	logic [LEN_W-1:0]  byte_index_q;
	logic [BYTE_W-1:0] running_crc_q;
	logic [BYTE_W-1:0] received_crc_q;
	logic [BYTE_W-1:0] text_store_q [TEXT_CHARS];

	logic              accept;
	logic [BYTE_W-1:0] b;
	logic [LEN_W-1:0]  next_index;
	logic              len_bad;
	logic              frame_ok;
	logic              is_init;
	logic              is_state;
	logic [TEXT_W-1:0] text_flat;

	assign accept     = rx.valid && rx.ready;
	assign b          = rx.rx_data;
	assign rx.ready   = !q_full;
	assign cfg.ready  = 1'b1;
	assign next_index = byte_index_q + LEN_W'(1);
	assign len_bad    = (b == '0) || (b > BYTE_W'(MAX_FRAME_PAYLOAD));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= START_MARKER_RST;
			end_marker_q   <= END_MARKER_RST;
			init_type_q    <= INIT_TYPE_RST;
			state_type_q   <= STATE_TYPE_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_START_MARKER: start_marker_q <= cfg.data;
				REG_END_MARKER:   end_marker_q   <= cfg.data;
				REG_INIT_TYPE:    init_type_q    <= cfg.data;
				REG_STATE_TYPE:   state_type_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
		end else if (accept) begin
			phase_q <= phase_d;
		end
	end

	always_comb begin
		phase_d = PH_HUNT;
		case (phase_q)
			PH_HUNT:    phase_d = (b == start_marker_q) ? PH_TYPE : PH_HUNT;
			PH_TYPE:    phase_d = PH_LEN;
			PH_LEN:     phase_d = len_bad ? PH_HUNT : PH_PAYLOAD;
			PH_PAYLOAD: phase_d = (next_index >= frame_length_q) ? PH_CRC : PH_PAYLOAD;
			PH_CRC:     phase_d = PH_END;
			PH_END:     phase_d = PH_HUNT;
			default:    phase_d = PH_HUNT;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			case (phase_q)
				PH_TYPE: begin
					frame_type_q  <= b;
					running_crc_q <= crc8_feed(CRC_INIT, b);
				end
				PH_LEN: begin
					if (!len_bad) begin
						frame_length_q <= b[LEN_W-1:0];
						byte_index_q   <= '0;
						running_crc_q  <= crc8_feed(running_crc_q, b);
					end
				end
				PH_PAYLOAD: begin
					if (byte_index_q < LEN_W'(TEXT_CHARS)) begin
						text_store_q[byte_index_q[TIDX_W-1:0]] <= b;
					end
					running_crc_q <= crc8_feed(running_crc_q, b);
					byte_index_q  <= next_index;
				end
				PH_CRC: received_crc_q <= b;
				default: ;
			endcase
		end
	end

	always_comb begin
		text_flat = '0;
		for (int i = 0; i < TEXT_CHARS; i++) begin
			text_flat[i*BYTE_W +: BYTE_W] = text_store_q[i];
		end
	end

	assign frame_ok = (phase_q == PH_END) && (b == end_marker_q)
		&& (running_crc_q == received_crc_q);
	assign is_init  = (frame_type_q == init_type_q);
	assign is_state = (frame_type_q == state_type_q);
	assign push     = accept && frame_ok && (is_init || is_state);

	always_comb begin
		rec.kind  = is_init ? KIND_INIT : KIND_STATE;
		rec.text  = text_flat;
		rec.count = '0;
		if (!is_init) begin
			rec.count = (frame_length_q < LEN_W'(TEXT_CHARS))
				? TEXT_LEN_W'(frame_length_q) : TEXT_LEN_W'(TEXT_CHARS);
		end
	end

endmodule
`default_nettype wire

/* sv/crc8cfr_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// crc8cfr_queue
// Short FIFO of frame records between the parser and the result stage.
// ----------------------------------------------------------------------------
module crc8cfr_queue import crc8cfr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire frame_rec_t  push_rec,
	input  wire logic        pop,
	output logic             full,
	output logic             not_empty,
	output frame_rec_t       head
);

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	frame_rec_t         mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(do_push) - CNT_W'(do_pop);
		end
	end

endmodule
`default_nettype wire

/* sv/crc8cfr_emit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// crc8cfr_emit
// Back end: pulls records from the queue, masks unused text bytes and holds
// the result in an output register until taken.
// ----------------------------------------------------------------------------
module crc8cfr_emit import crc8cfr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_not_empty,
	input  wire frame_rec_t  q_head,
	output logic             q_pop,
	crc8cfr_result_if.source res
);

	logic                  valid_q;
	logic                  kind_q;
	logic [TEXT_W-1:0]     text_q;
	logic [TEXT_LEN_W-1:0] len_q;
	logic                  load;
	logic [TEXT_W-1:0]     masked;

	assign load  = q_not_empty && (!valid_q || res.ready);
	assign q_pop = load;

	always_comb begin
		masked = '0;
		for (int i = 0; i < TEXT_CHARS_MAX; i++) begin
			if (TEXT_LEN_W'(i) < q_head.count) begin
				masked[i*BYTE_W +: BYTE_W] = q_head.text[i*BYTE_W +: BYTE_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= q_head.kind;
			text_q <= masked;
			len_q  <= q_head.count;
		end
	end

	assign res.valid       = valid_q;
	assign res.frame_kind  = kind_q;
	assign res.text_bytes  = text_q;
	assign res.text_length = len_q;

endmodule
`default_nettype wire

/* sv/crc8_checked_frame_receiver_unit.sv */
`default_nettype none
// Result path: once its end byte is accepted, a frame's record is written to the record
// queue, then loaded into the output register and offered; soonest when both are empty.
// Throughput: one byte per cycle; the parser stalls only while the two-entry
// record queue is full. Configuration writes take effect in the next cycle; the write channel is always ready.
// Reset: asynchronous; markers and type codes return to their defaults, the
// parser hunts for a start byte, queue and output register are empty.
// ----------------------------------------------------------------------------
// crc8_checked_frame_receiver_unit
// Byte-stream frame receiver with CRC8 check, producing init and state results.
// ----------------------------------------------------------------------------
module crc8_checked_frame_receiver_unit import crc8cfr_pkg::*; #(
	parameter int unsigned TEXT_CHARS = TEXT_CHARS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	crc8cfr_byte_if.sink     rx,
	crc8cfr_cfg_if.sink      cfg,
	crc8cfr_result_if.source res
);

	logic       push;
	frame_rec_t rec;
	logic       q_full;
	logic       q_not_empty;
	logic       q_pop;
	frame_rec_t q_head;

	crc8cfr_parser #(.TEXT_CHARS(TEXT_CHARS)) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.cfg    (cfg),
		.q_full (q_full),
		.push   (push),
		.rec    (rec)
	);

	crc8cfr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_rec  (rec),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	crc8cfr_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.res         (res)
	);

endmodule
`default_nettype wire

/* sv/crc8cfr_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// crc8cfr_checker
// Port-level checks on the result channel of the frame receiver.
// ----------------------------------------------------------------------------
module crc8cfr_checker import crc8cfr_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire logic                  out_kind,
	input wire logic [TEXT_W-1:0]     out_text,
	input wire logic [TEXT_LEN_W-1:0] out_len
);

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped while stalled");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_kind) && $stable(out_text) && $stable(out_len))
		else $error("result changed while stalled");

	a_init_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_kind |-> out_len == '0 && out_text == '0)
		else $error("init result carries text");

	a_state_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind |-> out_len != '0 && out_len <= TEXT_LEN_W'(TEXT_CHARS_MAX))
		else $error("state result length out of range");

endmodule

bind crc8_checked_frame_receiver_unit crc8cfr_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (res.valid),
	.out_ready (res.ready),
	.out_kind  (res.frame_kind),
	.out_text  (res.text_bytes),
	.out_len   (res.text_length)
);
`default_nettype wire
